// ----- rtl/int32_elementwise_alu_unit_defines.svh -----
// Assertion macros for the top-level RTL. Each use names its own label.
`ifndef INT32_ELEMENTWISE_ALU_UNIT_DEFINES_SVH
`define INT32_ELEMENTWISE_ALU_UNIT_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define I32ALU_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("i32alu: check failed");

// When the trigger holds, the outcome must hold in the following cycle.
`define I32ALU_ASSERT_NEXT(label, trig, outcome) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (outcome)) else $error("i32alu: next-cycle check failed");

`endif

// ----- rtl/i32alu_pkg.sv -----
`default_nettype none

package i32alu_pkg;

    typedef enum logic [4:0] {
        FN_ADD      = 5'd0,
        FN_SUB      = 5'd1,
        FN_MUL      = 5'd2,
        FN_FLOORDIV = 5'd3,
        FN_PYMOD    = 5'd4,
        FN_CMOD     = 5'd5,
        FN_EQ       = 5'd6,
        FN_NE       = 5'd7,
        FN_LT       = 5'd8,
        FN_LE       = 5'd9,
        FN_GT       = 5'd10,
        FN_GE       = 5'd11,
        FN_MAX      = 5'd12,
        FN_MIN      = 5'd13,
        FN_LAND     = 5'd14,
        FN_LOR      = 5'd15,
        FN_LXOR     = 5'd16,
        FN_AND      = 5'd17,
        FN_OR       = 5'd18,
        FN_XOR      = 5'd19,
        FN_SHL      = 5'd20,
        FN_SHR      = 5'd21,
        FN_COPYSIGN = 5'd22
    } t_func;

    // Control that travels with each item down the chain.
    typedef struct packed {
        logic  valid;
        t_func func;
        logic  last;
        logic  a_neg;
        logic  b_neg;
        logic  b_zero;
    } t_ctrl;

endpackage

`default_nettype wire

// ----- rtl/i32alu_front.sv -----
`default_nettype none

module i32alu_front #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_en,
    input  wire                         i_valid,
    input  wire [4:0]                   i_func,
    input  wire signed [DATA_WIDTH-1:0] i_a,
    input  wire signed [DATA_WIDTH-1:0] i_b,
    input  wire                         i_last,
    output i32alu_pkg::t_ctrl           o_ctrl,
    output logic [DATA_WIDTH-1:0]       o_a,
    output logic [DATA_WIDTH-1:0]       o_b,
    output logic [DATA_WIDTH-1:0]       o_ma,
    output logic [DATA_WIDTH-1:0]       o_mb,
    output logic [DATA_WIDTH-1:0]       o_simple
);

    localparam int SW = $clog2(DATA_WIDTH);
    localparam logic [DATA_WIDTH-1:0] W_VAL = (DATA_WIDTH)'(DATA_WIDTH);

    i32alu_pkg::t_ctrl           r_ctrl, n_ctrl;
    logic [DATA_WIDTH-1:0]       r_a, r_b, r_ma, r_mb, r_simple;
    logic [DATA_WIDTH-1:0]       n_ma, n_mb, n_simple;
    logic                        lt, gt, anz, bnz, sh_ok;
    logic [SW-1:0]               sh;
    logic signed [DATA_WIDTH-1:0] shr_val;

    always_comb begin
        n_ma  = i_a[DATA_WIDTH-1] ? (~i_a + 1'b1) : i_a;
        n_mb  = i_b[DATA_WIDTH-1] ? (~i_b + 1'b1) : i_b;
        lt    = i_a < i_b;
        gt    = i_b < i_a;
        anz   = |i_a;
        bnz   = |i_b;
        sh_ok = !i_b[DATA_WIDTH-1] && (i_b < W_VAL);
        sh    = i_b[SW-1:0];
        // Kept apart so that the shift stays arithmetic.
        shr_val = i_a >>> sh;
        n_ctrl.valid  = i_valid;
        n_ctrl.func   = i32alu_pkg::t_func'(i_func);
        n_ctrl.last   = i_last;
        n_ctrl.a_neg  = i_a[DATA_WIDTH-1];
        n_ctrl.b_neg  = i_b[DATA_WIDTH-1];
        n_ctrl.b_zero = !bnz;
        unique case (n_ctrl.func)
            i32alu_pkg::FN_ADD:      n_simple = i_a + i_b;
            i32alu_pkg::FN_SUB:      n_simple = i_a - i_b;
            i32alu_pkg::FN_EQ:       n_simple = DATA_WIDTH'(i_a == i_b);
            i32alu_pkg::FN_NE:       n_simple = DATA_WIDTH'(i_a != i_b);
            i32alu_pkg::FN_LT:       n_simple = DATA_WIDTH'(lt);
            i32alu_pkg::FN_LE:       n_simple = DATA_WIDTH'(!gt);
            i32alu_pkg::FN_GT:       n_simple = DATA_WIDTH'(gt);
            i32alu_pkg::FN_GE:       n_simple = DATA_WIDTH'(!lt);
            i32alu_pkg::FN_MAX:      n_simple = gt ? i_a : i_b;
            i32alu_pkg::FN_MIN:      n_simple = lt ? i_a : i_b;
            i32alu_pkg::FN_LAND:     n_simple = DATA_WIDTH'(anz && bnz);
            i32alu_pkg::FN_LOR:      n_simple = DATA_WIDTH'(anz || bnz);
            i32alu_pkg::FN_LXOR:     n_simple = DATA_WIDTH'(anz != bnz);
            i32alu_pkg::FN_AND:      n_simple = i_a & i_b;
            i32alu_pkg::FN_OR:       n_simple = i_a | i_b;
            i32alu_pkg::FN_XOR:      n_simple = i_a ^ i_b;
            i32alu_pkg::FN_SHL:      n_simple = sh_ok ? (i_a << sh) : '0;
            i32alu_pkg::FN_SHR:      n_simple = sh_ok ? shr_val : '0;
            i32alu_pkg::FN_COPYSIGN: n_simple = i_b[DATA_WIDTH-1] ? (~n_ma + 1'b1) : n_ma;
            default:                 n_simple = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a      <= i_a;
            r_b      <= i_b;
            r_ma     <= n_ma;
            r_mb     <= n_mb;
            r_simple <= n_simple;
        end
    end

    assign o_ctrl   = r_ctrl;
    assign o_a      = r_a;
    assign o_b      = r_b;
    assign o_ma     = r_ma;
    assign o_mb     = r_mb;
    assign o_simple = r_simple;

endmodule

`default_nettype wire

// ----- rtl/i32alu_cell.sv -----
`default_nettype none

// One step of the chain: one restoring division bit on the magnitudes and
// one shift-and-add multiply bit.
module i32alu_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  i32alu_pkg::t_ctrl     i_ctrl,
    input  wire [DATA_WIDTH-1:0]  i_a,
    input  wire [DATA_WIDTH-1:0]  i_b,
    input  wire [DATA_WIDTH-1:0]  i_ma,
    input  wire [DATA_WIDTH-1:0]  i_mb,
    input  wire [DATA_WIDTH-1:0]  i_simple,
    input  wire [DATA_WIDTH-1:0]  i_rem,
    input  wire [DATA_WIDTH-1:0]  i_quo,
    input  wire [DATA_WIDTH-1:0]  i_prod,
    output i32alu_pkg::t_ctrl     o_ctrl,
    output logic [DATA_WIDTH-1:0] o_a,
    output logic [DATA_WIDTH-1:0] o_b,
    output logic [DATA_WIDTH-1:0] o_ma,
    output logic [DATA_WIDTH-1:0] o_mb,
    output logic [DATA_WIDTH-1:0] o_simple,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_quo,
    output logic [DATA_WIDTH-1:0] o_prod
);

    localparam int BIT = DATA_WIDTH - 1 - IDX;

    i32alu_pkg::t_ctrl     r_ctrl;
    logic [DATA_WIDTH-1:0] r_a, r_b, r_ma, r_mb, r_simple, r_rem, r_quo, r_prod;
    logic [DATA_WIDTH-1:0] n_rem, n_quo, n_prod;
    logic [DATA_WIDTH:0]   trial, diff;
    logic                  fits;

    always_comb begin
        trial  = {i_rem, i_ma[BIT]};
        diff   = trial - {1'b0, i_mb};
        fits   = !diff[DATA_WIDTH];
        n_rem  = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        n_quo  = {i_quo[DATA_WIDTH-2:0], fits};
        n_prod = i_prod + (i_a[IDX] ? (i_b << IDX) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a      <= i_a;
            r_b      <= i_b;
            r_ma     <= i_ma;
            r_mb     <= i_mb;
            r_simple <= i_simple;
            r_rem    <= n_rem;
            r_quo    <= n_quo;
            r_prod   <= n_prod;
        end
    end

    assign o_ctrl   = r_ctrl;
    assign o_a      = r_a;
    assign o_b      = r_b;
    assign o_ma     = r_ma;
    assign o_mb     = r_mb;
    assign o_simple = r_simple;
    assign o_rem    = r_rem;
    assign o_quo    = r_quo;
    assign o_prod   = r_prod;

endmodule

`default_nettype wire

// ----- rtl/int32_elementwise_alu_unit.sv -----
// Element-wise integer ALU for streaming operand pairs.
// Input channel: i_valid / o_ready with i_func, i_operand_a, i_operand_b and
// i_last_in. A transfer happens on a rising edge where both are high.
// Output channel: o_valid / i_ready with o_result and o_last_out, which is a
// copy of the last-element mark of the same item.
// Throughput is one item per cycle while the receiver does not stall. An item
// passes through one front register that decodes the operands and computes the
// simple operations, a chain of DATA_WIDTH cells that each retire one quotient
// bit and one multiplier bit, and the output register that applies the floor
// and modulo sign fixes.
// When the receiver stalls with a result held, the whole chain freezes and
// o_ready drops; an empty output register never stalls the chain.
// Reset clears every valid flag in the chain and the output register; data
// registers are not reset.
`default_nettype none
`include "int32_elementwise_alu_unit_defines.svh"

module int32_elementwise_alu_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [4:0]                    i_func,
    input  wire signed [DATA_WIDTH-1:0]  i_operand_a,
    input  wire signed [DATA_WIDTH-1:0]  i_operand_b,
    input  wire                          i_last_in,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic signed [DATA_WIDTH-1:0] o_result,
    output logic                         o_last_out
);

    // Index 0 is the front stage output; index k+1 is the output of cell k.
    i32alu_pkg::t_ctrl     w_ctrl   [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] w_a      [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] w_b      [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] w_ma     [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] w_mb     [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] w_simple [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] w_rem    [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] w_quo    [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] w_prod   [DATA_WIDTH+1];

    logic                  w_en;
    logic                  r_valid;
    logic                  r_last;
    logic [DATA_WIDTH-1:0] r_result, n_result;

    // The chain moves as a whole whenever the output register can take data.
    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    i32alu_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .i_a      (i_operand_a),
        .i_b      (i_operand_b),
        .i_last   (i_last_in),
        .o_ctrl   (w_ctrl[0]),
        .o_a      (w_a[0]),
        .o_b      (w_b[0]),
        .o_ma     (w_ma[0]),
        .o_mb     (w_mb[0]),
        .o_simple (w_simple[0])
    );

    // The partial remainder, quotient and product start at zero.
    assign w_rem[0]  = '0;
    assign w_quo[0]  = '0;
    assign w_prod[0] = '0;

    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
        i32alu_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_ctrl   (w_ctrl[k]),
            .i_a      (w_a[k]),
            .i_b      (w_b[k]),
            .i_ma     (w_ma[k]),
            .i_mb     (w_mb[k]),
            .i_simple (w_simple[k]),
            .i_rem    (w_rem[k]),
            .i_quo    (w_quo[k]),
            .i_prod   (w_prod[k]),
            .o_ctrl   (w_ctrl[k+1]),
            .o_a      (w_a[k+1]),
            .o_b      (w_b[k+1]),
            .o_ma     (w_ma[k+1]),
            .o_mb     (w_mb[k+1]),
            .o_simple (w_simple[k+1]),
            .o_rem    (w_rem[k+1]),
            .o_quo    (w_quo[k+1]),
            .o_prod   (w_prod[k+1])
        );
    end

    // Sign fixes on the magnitude quotient and remainder. When the floor
    // correction applies the quotient is negative, so -q - 1 is just ~q.
    // A zero divisor forces a zero result for all three division codes.
    logic                  w_sdiff, w_rnz, w_aneg, w_bz;
    logic [DATA_WIDTH-1:0] w_uq, w_ur;

    always_comb begin
        w_uq    = w_quo[DATA_WIDTH];
        w_ur    = w_rem[DATA_WIDTH];
        w_aneg  = w_ctrl[DATA_WIDTH].a_neg;
        w_bz    = w_ctrl[DATA_WIDTH].b_zero;
        w_sdiff = w_aneg ^ w_ctrl[DATA_WIDTH].b_neg;
        w_rnz   = |w_ur;
        unique case (w_ctrl[DATA_WIDTH].func)
            i32alu_pkg::FN_MUL: begin
                n_result = w_prod[DATA_WIDTH];
            end
            i32alu_pkg::FN_FLOORDIV: begin
                if (w_bz) begin
                    n_result = '0;
                end else if (w_sdiff) begin
                    n_result = w_rnz ? ~w_uq : (~w_uq + 1'b1);
                end else begin
                    n_result = w_uq;
                end
            end
            i32alu_pkg::FN_PYMOD: begin
                if (w_bz) begin
                    n_result = '0;
                end else if (w_sdiff && w_rnz) begin
                    n_result = w_aneg ? (w_mb[DATA_WIDTH] - w_ur) : (w_ur - w_mb[DATA_WIDTH]);
                end else begin
                    n_result = w_aneg ? (~w_ur + 1'b1) : w_ur;
                end
            end
            i32alu_pkg::FN_CMOD: begin
                if (w_bz) begin
                    n_result = '0;
                end else begin
                    n_result = w_aneg ? (~w_ur + 1'b1) : w_ur;
                end
            end
            default: begin
                n_result = w_simple[DATA_WIDTH];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_ctrl[DATA_WIDTH].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_result <= n_result;
            r_last   <= w_ctrl[DATA_WIDTH].last;
        end
    end

    assign o_valid    = r_valid;
    assign o_result   = r_result;
    assign o_last_out = r_last;

    // An accepted item must show up in the front register.
    `I32ALU_ASSERT_NEXT(a_front_load, i_valid && o_ready, w_ctrl[0].valid)
    // An item leaving the last cell while the chain moves becomes a result.
    `I32ALU_ASSERT_NEXT(a_out_load, w_ctrl[DATA_WIDTH].valid && w_en, o_valid)
    // A held result must keep the chain frozen.
    `I32ALU_ASSERT(a_stall_freeze, !(o_valid && !i_ready && o_ready))

endmodule

`default_nettype wire
